// ===== rtl/pfa_pkg.sv =====
// Shared types and constants for the prime field arithmetic unit.
package pfa_pkg;

    localparam int LIMB_W = 64;
    localparam int FE_W   = 256;

    typedef logic [LIMB_W-1:0] limb_t;
    typedef logic [FE_W-1:0]   fe_t;

    typedef enum logic [2:0] {
        CMD_MUL = 3'd0,
        CMD_ADD = 3'd1,
        CMD_SUB = 3'd2,
        CMD_INV = 3'd3,
        CMD_POW = 3'd4
    } cmd_t;

    localparam fe_t PRIME     = {64'h7fffffffffffffff, 64'hffffffffffffffff,
                                 64'hffffffffffffffff, 64'hffffffffffffffed};
    localparam fe_t TWO_PRIME = {64'hffffffffffffffff, 64'hffffffffffffffff,
                                 64'hffffffffffffffff, 64'hffffffffffffffda};

    // Exponentiation schedule: rounds and skipped multiply rounds (counted from 0)
    localparam logic [7:0] INV_ROUNDS = 8'd254;
    localparam logic [7:0] INV_SKIP0  = 8'd249;
    localparam logic [7:0] INV_SKIP1  = 8'd251;
    localparam logic [7:0] POW_ROUNDS = 8'd251;
    localparam logic [7:0] POW_SKIP   = 8'd249;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDSUB,
        ST_SQR,
        ST_MULA,
        ST_WAIT,
        ST_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_PROD,
        MS_FOLD1,
        MS_FOLD2,
        MS_RED1,
        MS_RED2
    } mul_state_t;

endpackage

// ===== rtl/pfa_mulmod.sv =====
// Modular multiplier: one 64x64 product per cycle, then fold and reduce.
module pfa_mulmod (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  pfa_pkg::fe_t  x,
    input  pfa_pkg::fe_t  y,
    output logic          done,
    output pfa_pkg::fe_t  r
);
    import pfa_pkg::*;

    mul_state_t   state_reg, state_next;
    logic [3:0]   idx_reg, idx_next;
    fe_t          x_reg, y_reg;
    logic [511:0] acc_reg, acc_next;
    logic [127:0] pp_reg;
    logic         pp_vld_reg;
    logic [3:0]   pp_idx_reg;
    logic [263:0] t_reg, t_next;
    fe_t          r_reg, r_next;
    logic         done_reg, done_next;

    limb_t        xa, yb;
    logic [127:0] prod;
    logic [2:0]   pp_pos;
    logic [511:0] pp_sh;
    logic [263:0] fold_w;
    logic [256:0] red_w;

    // Limb select and shared multiplier
    assign xa   = x_reg[idx_reg[1:0]*LIMB_W +: LIMB_W];
    assign yb   = y_reg[idx_reg[3:2]*LIMB_W +: LIMB_W];
    assign prod = xa * yb;
    // Partial product lands at limb position i+j
    assign pp_pos = {1'b0, pp_idx_reg[1:0]} + {1'b0, pp_idx_reg[3:2]};
    assign pp_sh  = {384'd0, pp_reg} << {pp_pos, 6'd0};

    // Fold and reduce arithmetic
    always_comb
    begin
        fold_w = '0;
        red_w  = '0;
        case (state_reg)
            MS_FOLD1: fold_w = {8'd0, acc_reg[255:0]} + 264'(acc_reg[511:256]) * 264'd38;
            MS_FOLD2: fold_w = {8'd0, t_reg[255:0]} + 264'(t_reg[263:256]) * 264'd38;
            default:  fold_w = '0;
        endcase
        if (state_reg == MS_RED1)
            red_w = (t_reg[263:256] != 8'd0 || t_reg[255:0] >= TWO_PRIME)
                  ? {1'b0, t_reg[255:0]} + 257'd38 : {1'b0, t_reg[255:0]};
        else
            red_w = (r_reg >= PRIME) ? {1'b0, r_reg - PRIME} : {1'b0, r_reg};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            MS_IDLE:
                if (go)
                begin
                    state_next = MS_PROD;
                    idx_next   = '0;
                end
            MS_PROD:
            begin
                idx_next = idx_reg + 4'd1;
                if (pp_vld_reg && pp_idx_reg == 4'hf)
                    state_next = MS_FOLD1;
            end
            MS_FOLD1: state_next = MS_FOLD2;
            MS_FOLD2: state_next = MS_RED1;
            MS_RED1:  state_next = MS_RED2;
            MS_RED2:  state_next = MS_IDLE;
            default:  state_next = MS_IDLE;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        acc_next  = acc_reg;
        t_next    = t_reg;
        r_next    = r_reg;
        done_next = 1'b0;
        case (state_reg)
            MS_IDLE:  acc_next = '0;
            MS_PROD:  if (pp_vld_reg) acc_next = acc_reg + pp_sh;
            MS_FOLD1: t_next = fold_w;
            MS_FOLD2: t_next = fold_w;
            MS_RED1:  r_next = red_w[255:0];
            MS_RED2:
            begin
                r_next    = red_w[255:0];
                done_next = 1'b1;
            end
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= MS_IDLE;
            idx_reg    <= '0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            // valid for all sixteen products, dropped once the last one is summed
            pp_vld_reg <= (state_reg == MS_PROD) && !(pp_vld_reg && pp_idx_reg == 4'hf);
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MS_IDLE && go)
        begin
            x_reg <= x;
            y_reg <= y;
        end
        pp_reg     <= prod;
        pp_idx_reg <= idx_reg;
        acc_reg    <= acc_next;
        t_reg      <= t_next;
        r_reg      <= r_next;
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

// ===== rtl/prime_field_alu_25519.sv =====
// Top level: command decode, add/subtract, exponentiation sequencer.
// Multiply: a product phase on one 64x64 multiplier, then two folds and two
// reductions. Add/subtract and unknown commands bypass the multiplier.
// Inverse: 506 multiplies, power: 501 multiplies.
// One command at a time; busy stays high through the result strobe.
// Asynchronous active-low reset returns the sequencer to idle.
module prime_field_alu_25519 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  pfa_pkg::limb_t     operand_a_limb0,
    input  pfa_pkg::limb_t     operand_a_limb1,
    input  pfa_pkg::limb_t     operand_a_limb2,
    input  pfa_pkg::limb_t     operand_a_limb3,
    input  pfa_pkg::limb_t     operand_b_limb0,
    input  pfa_pkg::limb_t     operand_b_limb1,
    input  pfa_pkg::limb_t     operand_b_limb2,
    input  pfa_pkg::limb_t     operand_b_limb3,
    output logic               result_valid,
    output pfa_pkg::limb_t     result_limb0,
    output pfa_pkg::limb_t     result_limb1,
    output pfa_pkg::limb_t     result_limb2,
    output pfa_pkg::limb_t     result_limb3
);
    import pfa_pkg::*;

    top_state_t  state_reg, state_next;
    logic [2:0]  cmd_reg;
    fe_t         a_reg, b_reg, x_reg, x_next;
    logic [7:0]  round_reg, round_next;
    logic        valid_reg, valid_next;
    logic        accept;
    logic        go;
    fe_t         mx, my, mr;
    logic        mdone;
    logic        is_inv;
    logic [7:0]  last_round;
    logic        skip_mul;
    logic [256:0] sum_w;
    logic [256:0] dif_w;
    fe_t         as_res;

    pfa_mulmod u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (go),
        .x    (mx),
        .y    (my),
        .done (mdone),
        .r    (mr)
    );

    assign accept     = start && !busy;
    assign is_inv     = (cmd_reg == CMD_INV);
    assign last_round = is_inv ? INV_ROUNDS - 8'd1 : POW_ROUNDS - 8'd1;
    assign skip_mul   = is_inv ? (round_reg == INV_SKIP0 || round_reg == INV_SKIP1)
                               : (round_reg == POW_SKIP);

    // Add / subtract with one correction
    always_comb
    begin
        sum_w = {1'b0, a_reg} + {1'b0, b_reg};
        dif_w = {1'b0, a_reg} - {1'b0, b_reg};
        if (cmd_reg == CMD_ADD)
            as_res = (sum_w[256] || sum_w[255:0] >= PRIME) ? sum_w[255:0] - PRIME
                                                          : sum_w[255:0];
        else
            as_res = dif_w[256] ? dif_w[255:0] + PRIME : dif_w[255:0];
    end

    // Multiplier operand select: latched by the multiplier on go
    always_comb
    begin
        mx = x_reg;
        if (cmd_reg == CMD_MUL)
            my = b_reg;
        else if (state_reg == ST_WAIT)
            my = a_reg;
        else
            my = x_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        go         = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    case (cmd)
                        CMD_MUL: state_next = ST_WAIT;
                        CMD_ADD, CMD_SUB: state_next = ST_ADDSUB;
                        CMD_INV, CMD_POW: state_next = ST_SQR;
                        default: state_next = ST_DONE;
                    endcase
                end
            ST_ADDSUB: state_next = ST_DONE;
            ST_WAIT:
            begin
                go = 1'b1;
                state_next = ST_MULA;
            end
            ST_SQR:
            begin
                go = 1'b1;
                state_next = ST_MULA;
            end
            ST_MULA:
                if (mdone)
                begin
                    if (cmd_reg == CMD_MUL)
                        state_next = ST_DONE;
                    else if (!skip_mul && x_next != '1 && go == 1'b0)
                        state_next = ST_SQR;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and round bookkeeping (square / multiply phases)
    logic phase_reg, phase_next;
    always_comb
    begin
        x_next     = x_reg;
        phase_next = phase_reg;
        valid_next = 1'b0;
        if (accept)
        begin
            x_next     = (cmd == CMD_INV || cmd == CMD_POW || cmd == CMD_MUL)
                       ? {operand_a_limb3, operand_a_limb2, operand_a_limb1, operand_a_limb0}
                       : '0;
            phase_next = 1'b0;
        end
        if (state_reg == ST_ADDSUB)
            x_next = as_res;
        if (state_reg == ST_MULA && mdone)
            x_next = mr;
        if (state_reg == ST_DONE)
            valid_next = 1'b1;
    end

    // Override sequencing for exponent rounds, and return from ST_DONE to idle
    top_state_t st_fix;
    always_comb
    begin
        st_fix = state_next;
        if (state_reg == ST_MULA && mdone && cmd_reg != CMD_MUL)
        begin
            if (phase_reg == 1'b0 && !skip_mul)
                st_fix = ST_WAIT;
            else if (round_reg == last_round)
                st_fix = ST_DONE;
            else
                st_fix = ST_SQR;
        end
        if (state_reg == ST_DONE)
            st_fix = ST_IDLE;
    end

    always_comb
    begin
        round_next = round_reg;
        if (state_reg == ST_IDLE)
            round_next = '0;
        else if (state_reg == ST_MULA && mdone && cmd_reg != CMD_MUL
                 && (phase_reg == 1'b1 || skip_mul))
            round_next = round_reg + 8'd1;
    end

    // Phase: 0 = squaring, 1 = multiply by a
    logic phase_upd;
    always_comb
    begin
        phase_upd = phase_next;
        if (state_reg == ST_SQR)
            phase_upd = 1'b0;
        else if (state_reg == ST_WAIT && cmd_reg != CMD_MUL)
            phase_upd = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= st_fix;
            round_reg <= round_next;
            valid_reg <= valid_next;
            phase_reg <= phase_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            a_reg   <= {operand_a_limb3, operand_a_limb2, operand_a_limb1, operand_a_limb0};
            b_reg   <= {operand_b_limb3, operand_b_limb2, operand_b_limb1, operand_b_limb0};
        end
        x_reg <= x_next;
    end

    assign busy         = (state_reg != ST_IDLE) || valid_reg;
    assign result_valid = valid_reg;
    assign result_limb0 = x_reg[63:0];
    assign result_limb1 = x_reg[127:64];
    assign result_limb2 = x_reg[191:128];
    assign result_limb3 = x_reg[255:192];

endmodule

// ===== rtl/pfa_checker.sv =====
// Port-level checks for the prime field arithmetic unit.
module pfa_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid
);
    import pfa_pkg::*;

    // A start beat makes the unit busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("start beat did not set busy");

    // The strobe lasts one cycle
    a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("result strobe too long");

    // Strobe only while busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("strobe while idle");

    // After the strobe the unit is free again
    a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy) else $error("busy after result");

endmodule

bind prime_field_alu_25519 pfa_checker u_pfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .result_valid(result_valid)
);

// ===== tb/tb_prime_field_alu_25519.sv =====
// Self-checking testbench for the 2^255-19 field arithmetic unit.
module tb_prime_field_alu_25519;
    import pfa_pkg::*;

    localparam logic [2:0] CMD_TOP = 3'd7;
    localparam int N_RANDOM = 1500;
    localparam int LONG_OP_CYCLES = 16000;

    typedef struct {
        logic [2:0] op;
        fe_t        a;
        fe_t        b;
        int         gap;
    } beat_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    logic  [2:0] cmd = CMD_MUL;
    limb_t operand_a_limb0 = '0, operand_a_limb1 = '0, operand_a_limb2 = '0;
    limb_t operand_a_limb3 = '0;
    limb_t operand_b_limb0 = '0, operand_b_limb1 = '0, operand_b_limb2 = '0;
    limb_t operand_b_limb3 = '0;
    logic  result_valid;
    limb_t result_limb0, result_limb1, result_limb2, result_limb3;

    beat_t pending[$];
    fe_t   field_results[$];
    int    mismatches = 0;
    int    cycle_count = 0;
    int    cycle_limit = 100000;

    prime_field_alu_25519 dut (.*);

    always #2 clk = ~clk;

    // ---------------- field arithmetic predictor ----------------
    function automatic fe_t fe_mul(fe_t x, fe_t y);
        logic [511:0] prod;
        logic [263:0] t;
        logic [256:0] u;
        fe_t          r;
        prod = {256'd0, x} * {256'd0, y};
        t = {8'd0, prod[255:0]} + 264'(prod[511:256]) * 264'd38;
        u = {1'b0, t[255:0]} + 257'(t[263:256]) * 257'd38;
        r = u[255:0];
        if (u[256] || r >= TWO_PRIME)
            r = r + 256'd38;
        if (r >= PRIME)
            r = r - PRIME;
        return r;
    endfunction

    function automatic fe_t field_result(beat_t it);
        logic [256:0] s;
        fe_t          x;
        x = '0;
        case (it.op)
            CMD_MUL: x = fe_mul(it.a, it.b);
            CMD_ADD:
            begin
                s = {1'b0, it.a} + {1'b0, it.b};
                x = s[255:0];
                if (s[256] || x >= PRIME)
                    x = x - PRIME;
            end
            CMD_SUB:
            begin
                x = it.a - it.b;
                if (it.a < it.b)
                    x = x + PRIME;
            end
            CMD_INV:
            begin
                x = it.a;
                for (int i = 0; i < INV_ROUNDS; i++)
                begin
                    x = fe_mul(x, x);
                    if (i != INV_SKIP0 && i != INV_SKIP1)
                        x = fe_mul(x, it.a);
                end
            end
            CMD_POW:
            begin
                x = it.a;
                for (int i = POW_ROUNDS - 1; i >= 0; i--)
                begin
                    x = fe_mul(x, x);
                    // next-to-last round squares only
                    if (i != POW_ROUNDS - 1 - POW_SKIP)
                        x = fe_mul(x, it.a);
                end
            end
            default: x = '0;
        endcase
        return x;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic fe_t rand_fe();
        fe_t v;
        for (int i = 0; i < 8; i++)
            v[i*32 +: 32] = $urandom;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = fe_t'(1);
            2: v = PRIME - fe_t'($urandom_range(1, 3));
            3: v = PRIME + fe_t'($urandom_range(0, 3));
            4: v = '1;
            5: v = TWO_PRIME;
            6: v = v;                 // full 256-bit, possibly non-canonical
            default: v[255] = 1'b0;   // mostly canonical-ish
        endcase
        if (v[255] == 1'b0 && v >= PRIME && $urandom_range(0, 1) == 0)
            v = v - PRIME;
        return v;
    endfunction

    function automatic beat_t mk(logic [2:0] op, fe_t a, fe_t b, int gap);
        beat_t it;
        it.op = op;
        it.a = a;
        it.b = b;
        it.gap = gap;
        return it;
    endfunction

    // ---------------- driver ----------------
    beat_t cur;
    int    gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                field_results.push_back(field_result(cur));
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    cur = pending.pop_front();
                    gap_left = cur.gap;
                    if (gap_left > 0)
                    begin
                        // idle first, then present this beat
                        pending.push_front(cur);
                        cur.gap = 0;
                        pending[0].gap = 0;
                        gap_left--;
                        start <= 1'b0;
                    end
                    else
                    begin
                        cmd <= cur.op;
                        {operand_a_limb3, operand_a_limb2, operand_a_limb1,
                         operand_a_limb0} <= cur.a;
                        {operand_b_limb3, operand_b_limb2, operand_b_limb1,
                         operand_b_limb0} <= cur.b;
                        start <= 1'b1;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        fe_t got;
        fe_t want;
        got = {result_limb3, result_limb2, result_limb1, result_limb0};
        if (rst_n && result_valid)
        begin
            if (field_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
            end
            else
            begin
                want = field_results.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (got[i*64 +: 64] !== want[i*64 +: 64])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result_limb%0d: expected %h, got %h",
                                     i, want[i*64 +: 64], got[i*64 +: 64]);
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        fe_t max_fe;
        beat_t it;
        int long_ops;
        int burst;
        max_fe = '1;
        long_ops = 0;

        // directed: extremes, every operation, special cases
        pending.push_back(mk(CMD_MUL, '0, max_fe, 0));
        pending.push_back(mk(CMD_MUL, max_fe, max_fe, 0));
        pending.push_back(mk(CMD_MUL, PRIME - 1, PRIME - 1, 1));
        pending.push_back(mk(CMD_MUL, PRIME, fe_t'(1), 0));
        pending.push_back(mk(CMD_MUL, TWO_PRIME, TWO_PRIME - 1, 2));
        pending.push_back(mk(CMD_ADD, PRIME - 1, fe_t'(1), 0));
        pending.push_back(mk(CMD_ADD, max_fe, max_fe, 0));
        pending.push_back(mk(CMD_ADD, '0, '0, 3));
        pending.push_back(mk(CMD_ADD, PRIME - 1, PRIME - 1, 0));
        pending.push_back(mk(CMD_SUB, '0, fe_t'(1), 0));
        pending.push_back(mk(CMD_SUB, max_fe, '0, 1));
        pending.push_back(mk(CMD_SUB, '0, max_fe, 0));
        pending.push_back(mk(CMD_SUB, PRIME - 1, PRIME - 1, 0));
        pending.push_back(mk(CMD_INV, '0, max_fe, 0));
        pending.push_back(mk(CMD_INV, fe_t'(1), '0, 0));
        pending.push_back(mk(CMD_INV, PRIME, '0, 2));
        pending.push_back(mk(CMD_INV, max_fe, '0, 0));
        pending.push_back(mk(CMD_POW, fe_t'(2), '0, 0));
        pending.push_back(mk(CMD_POW, max_fe, max_fe, 1));
        for (int u = CMD_POW + 1; u <= CMD_TOP; u++)
            pending.push_back(mk(3'(u), max_fe, max_fe, 0));
        long_ops = 6;

        // random: mostly short ops, rare exponentiations; bursts without gaps
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            int pick;
            if (burst == 0)
                burst = ($urandom_range(0, 3) == 0) ? -$urandom_range(10, 40)
                                                    : $urandom_range(10, 40);
            pick = $urandom_range(0, 99);
            if (pick < 35)
                it.op = CMD_MUL;
            else if (pick < 65)
                it.op = CMD_ADD;
            else if (pick < 95)
                it.op = CMD_SUB;
            else if (pick < 97)
                it.op = 3'($urandom_range(CMD_POW + 1, CMD_TOP));
            else if (pick < 98)
                it.op = CMD_INV;
            else
                it.op = CMD_POW;
            if (it.op == CMD_INV || it.op == CMD_POW)
                long_ops++;
            it.a = rand_fe();
            it.b = rand_fe();
            it.gap = (burst < 0) ? 0 : $urandom_range(0, 3);
            burst = (burst < 0) ? burst + 1 : burst - 1;
            pending.push_back(it);
        end
        cycle_limit = 4 * (long_ops * LONG_OP_CYCLES + pending.size() * 40) + 10000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending.size() == 0 && !start && field_results.size() == 0))
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && field_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== prime_field_alu_25519.f =====
rtl/pfa_pkg.sv
rtl/pfa_mulmod.sv
rtl/prime_field_alu_25519.sv
rtl/pfa_checker.sv
tb/tb_prime_field_alu_25519.sv
